// File: design/pcif_pkg.sv
package pcif_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int IDX_W     = 18;
    localparam int ROW_W     = 24;
    localparam int CSZ_W     = 7;
    localparam int ENT_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int BIT_CNT_W = $clog2(COORD_W);

    // running candidate value: coordinate plus a few shifted matrix rows
    localparam int VAL_W = 18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CSZ_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CSZ_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CSZ_C    = 3'd5;

    // reset values: identity matrix, unit cell
    localparam logic [ROW_W-1:0] ROW_ZERO_RST = 24'h000001;
    localparam logic [ROW_W-1:0] ROW_ONE_RST  = 24'h000100;
    localparam logic [ROW_W-1:0] ROW_TWO_RST  = 24'h010000;
    localparam logic [CSZ_W-1:0] CSZ_RST      = 7'd1;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [ENT_W-1:0] ent_t;

endpackage

// File: design/periodic_cluster_index_fold.sv
// paths: zero cell size goes to DONE; diagonal matrix runs DIV (bitwise remainder per axis), DFIX, MUL0, MUL1
// search: per shell Nmax a START step plus up to (2*Nmax+2)^3 candidates, one per cycle, then MUL0, MUL1
// worst case searches all MAX_SHELL shells through the single candidate checker
// one item at a time: s_ready is high only while idle; a finished item waits in the output reg
// aresetn is synchronous, active low: matrix returns to identity, cell sizes to one
module periodic_cluster_index_fold
    import pcif_pkg::*;
#(
    parameter int MAX_CELL_SIZE = 64,
    parameter int MAX_SHELL     = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ROW_W-1:0]            cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_W-1:0]   s_coord_a,
    input  logic signed [COORD_W-1:0]   s_coord_b,
    input  logic signed [COORD_W-1:0]   s_coord_c,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [IDX_W-1:0]            m_linear_index,
    output logic                        m_not_found
);

    localparam int SW = $clog2(MAX_CELL_SIZE + 1);
    localparam int NW = $clog2(MAX_SHELL + 1);
    localparam int CW = $clog2(MAX_SHELL + 2) + 1;
    localparam int TW = 2 * SW;
    localparam int PW = 3 * SW + 1;

    typedef enum logic [2:0] {
        IDLE, DIV, DFIX, START, SEARCH, MUL0, MUL1, DONE
    } state_t;

    state_t                     state_reg;
    logic [ROW_W-1:0]           row_reg [3];
    logic [CSZ_W-1:0]           csz_reg [3];
    logic signed [COORD_W-1:0]  p_reg [3];
    logic [COORD_W-1:0]         mag_reg [3];
    logic                       neg_reg [3];
    logic [SW-1:0]              rem_reg [3];
    logic [BIT_CNT_W-1:0]       bit_cnt_reg;
    val_t                       off_reg [3][3];
    val_t                       vl_reg [3];
    val_t                       vm_reg [3];
    val_t                       vn_reg [3];
    logic signed [CW-1:0]       l_reg, m_reg, n_reg;
    logic [NW-1:0]              nmax_reg;
    logic [SW-1:0]              x_reg [3];
    logic [TW-1:0]              t_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic                       nf_reg;
    logic                       m_valid_reg;
    logic [IDX_W-1:0]           m_idx_reg;
    logic                       m_nf_reg;

    logic [SW-1:0]              sz [3];
    val_t                       ent [3][3];
    logic [SW:0]                shifted [3];
    logic                       hit [3];
    logic                       hit_all;
    logic                       diag;
    logic                       size_zero;
    logic signed [CW-1:0]       nmax_s, nfirst, nlast;
    logic [PW-1:0]              prod;

    // clamped cell sizes and sign-extended matrix entries
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sz[c] = (int'(csz_reg[c]) > MAX_CELL_SIZE) ? SW'(MAX_CELL_SIZE) : SW'(csz_reg[c]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ent[r][c] = VAL_W'(ent_t'(row_reg[r][ENT_W*c +: ENT_W]));
            end
        end
    end

    // matrix shape and degenerate cell
    assign diag = (ent[0][1] == '0) && (ent[0][2] == '0) && (ent[1][0] == '0)
               && (ent[1][2] == '0) && (ent[2][0] == '0) && (ent[2][1] == '0);
    assign size_zero = (sz[0] == '0) || (sz[1] == '0) || (sz[2] == '0);

    // remainder step and candidate range check, one lane per axis
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = {rem_reg[c], mag_reg[c][bit_cnt_reg]};
            hit[c] = !vn_reg[c][VAL_W-1] && ($unsigned(vn_reg[c]) < VAL_W'(sz[c]));
        end
        hit_all = hit[0] && hit[1] && hit[2];
    end

    // shell bounds
    assign nmax_s = CW'(nmax_reg);
    assign nfirst = -nmax_s;
    assign nlast  = nmax_s + CW'(1);

    // index product for the second multiply step
    assign prod = PW'(t_reg) * PW'(sz[2]) + PW'(x_reg[2]);

    // sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            row_reg[0]  <= ROW_ZERO_RST;
            row_reg[1]  <= ROW_ONE_RST;
            row_reg[2]  <= ROW_TWO_RST;
            csz_reg[0]  <= CSZ_RST;
            csz_reg[1]  <= CSZ_RST;
            csz_reg[2]  <= CSZ_RST;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROW_ZERO: row_reg[0] <= cfg_wr_data;
                    REG_ROW_ONE:  row_reg[1] <= cfg_wr_data;
                    REG_ROW_TWO:  row_reg[2] <= cfg_wr_data;
                    REG_CSZ_A:    csz_reg[0] <= cfg_wr_data[CSZ_W-1:0];
                    REG_CSZ_B:    csz_reg[1] <= cfg_wr_data[CSZ_W-1:0];
                    REG_CSZ_C:    csz_reg[2] <= cfg_wr_data[CSZ_W-1:0];
                    default: ;
                endcase
            end

            // result taken, unless a new one loads this cycle
            if (m_valid_reg && m_ready && state_reg != DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        p_reg[0] <= s_coord_a;
                        p_reg[1] <= s_coord_b;
                        p_reg[2] <= s_coord_c;
                        mag_reg[0] <= s_coord_a[COORD_W-1] ? COORD_W'(-s_coord_a) : s_coord_a;
                        mag_reg[1] <= s_coord_b[COORD_W-1] ? COORD_W'(-s_coord_b) : s_coord_b;
                        mag_reg[2] <= s_coord_c[COORD_W-1] ? COORD_W'(-s_coord_c) : s_coord_c;
                        neg_reg[0] <= s_coord_a[COORD_W-1];
                        neg_reg[1] <= s_coord_b[COORD_W-1];
                        neg_reg[2] <= s_coord_c[COORD_W-1];
                        for (int c = 0; c < 3; c++) begin
                            rem_reg[c] <= '0;
                        end
                        for (int r = 0; r < 3; r++) begin
                            for (int c = 0; c < 3; c++) begin
                                off_reg[r][c] <= ent[r][c];
                            end
                        end
                        bit_cnt_reg <= BIT_CNT_W'(COORD_W - 1);
                        nmax_reg    <= NW'(1);
                        nf_reg      <= size_zero;
                        if (size_zero) begin
                            state_reg <= DONE;
                        end else if (diag) begin
                            state_reg <= DIV;
                        end else begin
                            state_reg <= START;
                        end
                    end
                end

                // restoring remainder, one bit of |coord| per cycle on each axis
                DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        rem_reg[c] <= (shifted[c] >= {1'b0, sz[c]})
                                    ? SW'(shifted[c] - {1'b0, sz[c]}) : SW'(shifted[c]);
                    end
                    if (bit_cnt_reg == '0) begin
                        state_reg <= DFIX;
                    end else begin
                        bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
                    end
                end

                // negative coordinate with nonzero remainder wraps from the top
                DFIX: begin
                    for (int c = 0; c < 3; c++) begin
                        x_reg[c] <= (neg_reg[c] && rem_reg[c] != '0)
                                  ? sz[c] - rem_reg[c] : rem_reg[c];
                    end
                    state_reg <= MUL0;
                end

                // first candidate of a shell: L = M = N = -Nmax
                START: begin
                    for (int c = 0; c < 3; c++) begin
                        vl_reg[c] <= VAL_W'(p_reg[c]) + off_reg[0][c];
                        vm_reg[c] <= VAL_W'(p_reg[c]) + off_reg[0][c] + off_reg[1][c];
                        vn_reg[c] <= VAL_W'(p_reg[c]) + off_reg[0][c] + off_reg[1][c]
                                   + off_reg[2][c];
                    end
                    l_reg     <= nfirst;
                    m_reg     <= nfirst;
                    n_reg     <= nfirst;
                    state_reg <= SEARCH;
                end

                // check one candidate a cycle, then step N, M, L in that order
                SEARCH: begin
                    if (hit_all) begin
                        for (int c = 0; c < 3; c++) begin
                            x_reg[c] <= vn_reg[c][SW-1:0];
                        end
                        state_reg <= MUL0;
                    end else if (n_reg != nlast) begin
                        n_reg <= n_reg + CW'(1);
                        for (int c = 0; c < 3; c++) begin
                            vn_reg[c] <= vn_reg[c] - ent[2][c];
                        end
                    end else if (m_reg != nlast) begin
                        m_reg <= m_reg + CW'(1);
                        n_reg <= nfirst;
                        for (int c = 0; c < 3; c++) begin
                            vm_reg[c] <= vm_reg[c] - ent[1][c];
                            vn_reg[c] <= vm_reg[c] - ent[1][c] + off_reg[2][c];
                        end
                    end else if (l_reg != nlast) begin
                        l_reg <= l_reg + CW'(1);
                        m_reg <= nfirst;
                        n_reg <= nfirst;
                        for (int c = 0; c < 3; c++) begin
                            vl_reg[c] <= vl_reg[c] - ent[0][c];
                            vm_reg[c] <= vl_reg[c] - ent[0][c] + off_reg[1][c];
                            vn_reg[c] <= vl_reg[c] - ent[0][c] + off_reg[1][c]
                                       + off_reg[2][c];
                        end
                    end else if (nmax_reg == NW'(MAX_SHELL)) begin
                        nf_reg    <= 1'b1;
                        state_reg <= DONE;
                    end else begin
                        // next shell: offsets grow by one row each
                        nmax_reg <= nmax_reg + NW'(1);
                        for (int r = 0; r < 3; r++) begin
                            for (int c = 0; c < 3; c++) begin
                                off_reg[r][c] <= off_reg[r][c] + ent[r][c];
                            end
                        end
                        state_reg <= START;
                    end
                end

                // index = (x0 * d1 + x1) * d2 + x2
                MUL0: begin
                    t_reg     <= TW'(x_reg[0]) * TW'(sz[1]) + TW'(x_reg[1]);
                    state_reg <= MUL1;
                end

                MUL1: begin
                    idx_reg   <= IDX_W'(prod);
                    state_reg <= DONE;
                end

                DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= nf_reg ? '0 : idx_reg;
                        m_nf_reg    <= nf_reg;
                        state_reg   <= IDLE;
                    end
                end

                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == IDLE);
    assign m_valid        = m_valid_reg;
    assign m_linear_index = m_idx_reg;
    assign m_not_found    = m_nf_reg;

endmodule

// File: design/pcif_checker.sv
module pcif_checker
    import pcif_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [IDX_W-1:0]     m_linear_index,
    input logic                 m_not_found
);

    // a not-found item carries a zero index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_not_found |-> m_linear_index == '0)
        else $error("not-found item with nonzero index");

    // the block goes busy right after taking an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an item was taken");

    // a new result only comes out of a busy block
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_linear_index) && $stable(m_not_found))
        else $error("stalled result changed");

endmodule

bind periodic_cluster_index_fold pcif_checker u_pcif_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_linear_index (m_linear_index),
    .m_not_found    (m_not_found)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pcif_pkg::*;

    localparam int CELL_LIMIT  = 64;
    localparam int SHELL_LIMIT = 4;

    // one result per item: folded index and the miss flag
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             not_found;
    } fold_t;

    // configuration set used by the directed table
    typedef struct {
        logic [ROW_W-1:0] row0;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
        logic [CSZ_W-1:0] size_a;
        logic [CSZ_W-1:0] size_b;
        logic [CSZ_W-1:0] size_c;
    } cell_cfg_t;

    // directed item: config set, coordinate, and a typed result where obvious
    typedef struct {
        int                 cfg_no;
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] coord_b;
        logic [COORD_W-1:0] coord_c;
        bit                 typed;
        logic [IDX_W-1:0]   want_index;
        bit                 want_nf;
    } coord_row_t;

    typedef enum {
        KIND_DIAG,
        KIND_DIAG_SAT,
        KIND_ZERO,
        KIND_SKEW,
        KIND_SKEW_EXT
    } cfg_kind_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [ROW_W-1:0]          cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_coord_a;
    logic signed [COORD_W-1:0] s_coord_b;
    logic signed [COORD_W-1:0] s_coord_c;
    logic                      m_valid;
    logic                      m_ready;
    logic [IDX_W-1:0]          m_linear_index;
    logic                      m_not_found;

    // copy of the block's registers as the testbench last wrote them
    logic [ROW_W-1:0] shadow_row [3];
    logic [CSZ_W-1:0] shadow_size [3];

    fold_t expected_folds [$];
    int    mismatch_count = 0;
    int    send_idle_pct;
    int    recv_idle_pct;

    cell_cfg_t directed_cfgs [8] = '{
        '{ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, 7'd1, 7'd1, 7'd1},
        '{24'h000005, 24'h00F900, 24'h7F0000, 7'd64, 7'd64, 7'd64},
        '{ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, 7'd127, 7'd100, 7'd64},
        '{ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST, 7'd0, 7'd5, 7'd5},
        '{24'h000101, ROW_ONE_RST, ROW_TWO_RST, 7'd5, 7'd0, 7'd5},
        '{24'h000104, 24'h000400, 24'h040000, 7'd4, 7'd4, 7'd4},
        '{24'hFF7F80, 24'h00807F, 24'h800000, 7'd64, 7'd64, 7'd64},
        '{24'h000102, 24'h000300, ROW_TWO_RST, 7'd1, 7'd1, 7'd1}
    };

    coord_row_t directed_rows [22] = '{
        // unit cell after reset: everything folds to zero
        '{0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 18'd0, 1'b0},
        '{0, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 18'd0, 1'b0},
        '{0, 16'h8000, 16'h7FFF, 16'h0000, 1'b1, 18'd0, 1'b0},
        // diagonal with odd diagonal entries, full 64 cell
        '{1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 18'd262143, 1'b0},
        '{1, 16'h7FFF, 16'h8000, 16'h0000, 1'b1, 18'd258048, 1'b0},
        '{1, 16'h0040, 16'hFFC0, 16'h0005, 1'b1, 18'd5, 1'b0},
        // oversized cell sizes saturate
        '{2, 16'h003F, 16'h0040, 16'hFFBF, 1'b1, 18'd258111, 1'b0},
        '{2, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 18'd4032, 1'b0},
        // zero cell size on the diagonal path and on the search path
        '{3, 16'h0001, 16'h0002, 16'h0003, 1'b1, 18'd0, 1'b1},
        '{4, 16'h0001, 16'h0002, 16'h0003, 1'b1, 18'd0, 1'b1},
        '{4, 16'h0000, 16'h0000, 16'h0000, 1'b1, 18'd0, 1'b1},
        // skewed matrix, small cell
        '{5, 16'h0001, 16'h0002, 16'h0003, 1'b0, 18'd0, 1'b0},
        '{5, 16'h0005, 16'h0001, 16'h0000, 1'b0, 18'd0, 1'b0},
        '{5, 16'h0064, 16'h0000, 16'h0000, 1'b0, 18'd0, 1'b0},
        '{5, 16'hFFF9, 16'hFFFB, 16'h0006, 1'b0, 18'd0, 1'b0},
        // extreme matrix entries
        '{6, 16'h0000, 16'h0000, 16'h0000, 1'b0, 18'd0, 1'b0},
        '{6, 16'hFF80, 16'h007F, 16'hFFFF, 1'b0, 18'd0, 1'b0},
        '{6, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 18'd0, 1'b0},
        '{6, 16'h8000, 16'h8000, 16'h8000, 1'b0, 18'd0, 1'b0},
        '{6, 16'hFF00, 16'h00FF, 16'h0082, 1'b0, 18'd0, 1'b0},
        // skewed matrix with a unit cell
        '{7, 16'h0002, 16'h0001, 16'h0000, 1'b0, 18'd0, 1'b0},
        '{7, 16'h0003, 16'h0004, 16'h0001, 1'b0, 18'd0, 1'b0}
    };

    cfg_kind_t random_plan [11] = '{
        KIND_DIAG, KIND_SKEW, KIND_SKEW_EXT, KIND_DIAG_SAT,
        KIND_SKEW, KIND_ZERO, KIND_SKEW, KIND_DIAG,
        KIND_SKEW_EXT, KIND_SKEW, KIND_DIAG
    };

    periodic_cluster_index_fold #(
        .MAX_CELL_SIZE (CELL_LIMIT),
        .MAX_SHELL     (SHELL_LIMIT)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coord_a      (s_coord_a),
        .s_coord_b      (s_coord_b),
        .s_coord_c      (s_coord_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_linear_index (m_linear_index),
        .m_not_found    (m_not_found)
    );

    // clock
    always #4 aclk = ~aclk;

    // signed matrix entry, row r column c
    function automatic int row_entry(input int r, input int c);
        return int'(ent_t'(shadow_row[r][8*c +: 8]));
    endfunction

    // cell extent after saturation
    function automatic int cell_extent(input int k);
        return (shadow_size[k] > CELL_LIMIT) ? CELL_LIMIT : int'(shadow_size[k]);
    endfunction

    // fold one coordinate into the cell under the current registers
    function automatic fold_t fold_coord(input logic signed [COORD_W-1:0] ca,
                                         input logic signed [COORD_W-1:0] cb,
                                         input logic signed [COORD_W-1:0] cc);
        int          pos [3];
        int          ext [3];
        int          ent [3][3];
        int          x [3];
        int          v;
        bit          flat;
        bit          hit;
        bit          ok;
        logic [31:0] lin;
        fold_t       res;
        pos = '{int'(ca), int'(cb), int'(cc)};
        flat = 1'b1;
        hit = 1'b0;
        x = '{0, 0, 0};
        for (int r = 0; r < 3; r++) begin
            ext[r] = cell_extent(r);
            for (int c = 0; c < 3; c++) begin
                ent[r][c] = row_entry(r, c);
                if (r != c && ent[r][c] != 0) flat = 1'b0;
            end
        end
        if (ext[0] == 0 || ext[1] == 0 || ext[2] == 0) begin
            hit = 1'b0;
        end else if (flat) begin
            // plain non-negative modulo per axis
            for (int c = 0; c < 3; c++) begin
                x[c] = pos[c] % ext[c];
                if (x[c] < 0) x[c] += ext[c];
            end
            hit = 1'b1;
        end else begin
            // shell search, first match wins
            for (int nmax = 1; nmax <= SHELL_LIMIT && !hit; nmax++)
                for (int l = -nmax; l <= nmax + 1 && !hit; l++)
                    for (int m = -nmax; m <= nmax + 1 && !hit; m++)
                        for (int n = -nmax; n <= nmax + 1 && !hit; n++) begin
                            ok = 1'b1;
                            for (int c = 0; c < 3; c++) begin
                                v = pos[c] - l * ent[0][c] - m * ent[1][c] - n * ent[2][c];
                                if (v < 0 || v >= ext[c]) ok = 1'b0;
                                x[c] = v;
                            end
                            if (ok) hit = 1'b1;
                        end
        end
        if (hit) begin
            lin = 32'(x[0]) * 32'(ext[1] * ext[2]) + 32'(x[1]) * 32'(ext[2]) + 32'(x[2]);
            res.index = lin[IDX_W-1:0];
            res.not_found = 1'b0;
        end else begin
            res.index = '0;
            res.not_found = 1'b1;
        end
        return res;
    endfunction

    // point inside the cell pushed out by a few matrix rows
    function automatic void lattice_point(output logic [COORD_W-1:0] ca,
                                          output logic [COORD_W-1:0] cb,
                                          output logic [COORD_W-1:0] cc);
        int   shift [3];
        int   ext;
        int   val;
        logic [COORD_W-1:0] pt [3];
        for (int r = 0; r < 3; r++)
            shift[r] = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 9)) - 4
                                                   : int'($urandom_range(0, 3)) - 1;
        for (int c = 0; c < 3; c++) begin
            ext = cell_extent(c);
            val = (ext == 0) ? 0 : int'($urandom_range(0, ext - 1));
            for (int r = 0; r < 3; r++) val += shift[r] * row_entry(r, c);
            pt[c] = val[COORD_W-1:0];
        end
        ca = pt[0];
        cb = pt[1];
        cc = pt[2];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // drain, then write all six registers
    task automatic write_config(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                                input logic [ROW_W-1:0] r2, input logic [CSZ_W-1:0] sa,
                                input logic [CSZ_W-1:0] sb, input logic [CSZ_W-1:0] sc);
        logic [ROW_W-1:0]     vals [6];
        logic [CFG_IDX_W-1:0] regs [6];
        s_valid <= 1'b0;
        regs = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO, REG_CSZ_A, REG_CSZ_B, REG_CSZ_C};
        vals = '{r0, r1, r2, ROW_W'(sa), ROW_W'(sb), ROW_W'(sc)};
        wait (expected_folds.size() == 0);
        @(posedge aclk);
        for (int k = 0; k < 6; k++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= regs[k];
            cfg_wr_data <= vals[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        shadow_row  = '{r0, r1, r2};
        shadow_size = '{sa, sb, sc};
    endtask

    // random register set of the given flavor
    task automatic apply_random_config(input cfg_kind_t kind);
        logic [ENT_W-1:0] ent [3][3];
        logic [CSZ_W-1:0] sz [3];
        bit               skewed;
        skewed = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                case (kind)
                    KIND_ZERO, KIND_SKEW_EXT: begin
                        ent[r][c] = ENT_W'($urandom);
                    end
                    KIND_SKEW: begin
                        ent[r][c] = (r == c) ? ENT_W'($urandom_range(1, 8))
                                             : ENT_W'(int'($urandom_range(0, 8)) - 4);
                    end
                    default: begin
                        ent[r][c] = (r == c) ? ENT_W'($urandom) : '0;
                    end
                endcase
                if (r != c && ent[r][c] != 0) skewed = 1'b1;
            end
            case (kind)
                KIND_DIAG:     sz[r] = CSZ_W'($urandom_range(1, 64));
                KIND_DIAG_SAT: sz[r] = $urandom_range(0, 1) ? 7'd64
                                                            : CSZ_W'($urandom_range(65, 127));
                KIND_ZERO:     sz[r] = CSZ_W'($urandom_range(0, 127));
                KIND_SKEW:     sz[r] = CSZ_W'($urandom_range(1, 8));
                default:       sz[r] = CSZ_W'($urandom_range(1, 64));
            endcase
        end
        if (kind == KIND_ZERO) sz[$urandom_range(0, 2)] = '0;
        if ((kind == KIND_SKEW || kind == KIND_SKEW_EXT) && !skewed) ent[0][1] = 8'h01;
        write_config({ent[0][2], ent[0][1], ent[0][0]}, {ent[1][2], ent[1][1], ent[1][0]},
                     {ent[2][2], ent[2][1], ent[2][0]}, sz[0], sz[1], sz[2]);
    endtask

    // offer one item and record its expected fold once accepted
    task automatic send_coord(input logic [COORD_W-1:0] ca, input logic [COORD_W-1:0] cb,
                              input logic [COORD_W-1:0] cc, input bit typed,
                              input fold_t typed_fold);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_coord_a <= ca;
        s_coord_b <= cb;
        s_coord_c <= cc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_folds.insert(expected_folds.size(),
                              typed ? typed_fold : fold_coord(ca, cb, cc));
    endtask

    // result side stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare each result with the oldest expected fold
    always @(posedge aclk) begin : result_check
        fold_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_folds.size() == 0) begin
                report_mismatch("result with nothing pending", int'(m_linear_index), -1);
            end else begin
                want = expected_folds.pop_front();
                if (m_linear_index !== want.index)
                    report_mismatch("linear_index", int'(m_linear_index), int'(want.index));
                if (m_not_found !== want.not_found)
                    report_mismatch("not_found", int'(m_not_found), int'(want.not_found));
            end
        end
    end

    // main sequence
    initial begin
        fold_t              typed_fold;
        logic [COORD_W-1:0] ca;
        logic [COORD_W-1:0] cb;
        logic [COORD_W-1:0] cc;
        int                 cur_cfg;
        cell_cfg_t          cfg;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_ROW_ZERO;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_coord_a   <= '0;
        s_coord_b   <= '0;
        s_coord_c   <= '0;
        send_idle_pct = 18;
        recv_idle_pct = 53;
        shadow_row  = '{ROW_ZERO_RST, ROW_ONE_RST, ROW_TWO_RST};
        shadow_size = '{CSZ_RST, CSZ_RST, CSZ_RST};
        cur_cfg = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_no != cur_cfg) begin
                cur_cfg = directed_rows[i].cfg_no;
                cfg = directed_cfgs[cur_cfg];
                write_config(cfg.row0, cfg.row1, cfg.row2, cfg.size_a, cfg.size_b, cfg.size_c);
            end
            typed_fold.index = directed_rows[i].want_index;
            typed_fold.not_found = directed_rows[i].want_nf;
            send_coord(directed_rows[i].coord_a, directed_rows[i].coord_b,
                       directed_rows[i].coord_c, directed_rows[i].typed, typed_fold);
        end

        // random sets, idling pattern changes by thirds
        typed_fold = '0;
        foreach (random_plan[s]) begin
            if (s == 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 18;
            end else if (s == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_random_config(random_plan[s]);
            repeat (30) begin
                if ((random_plan[s] == KIND_SKEW || random_plan[s] == KIND_SKEW_EXT)
                        && $urandom_range(0, 4) != 0) begin
                    lattice_point(ca, cb, cc);
                end else begin
                    ca = COORD_W'($urandom);
                    cb = COORD_W'($urandom);
                    cc = COORD_W'($urandom);
                end
                send_coord(ca, cb, cc, 1'b0, typed_fold);
            end
        end

        // drain and settle
        s_valid <= 1'b0;
        wait (expected_folds.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
